// File: hw/rtl/bca_pkg.sv
// shared types and constants of the block chain allocator
package bca_pkg;

   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_CHECK = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_LOAD  = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_BADLINK = 3'd2;
   localparam logic [2:0] ST_FREEIN  = 3'd3;
   localparam logic [2:0] ST_SHORT   = 3'd4;
   localparam logic [2:0] ST_RANGE   = 3'd5;

   localparam logic [11:0] LINK_END     = 12'h001;
   localparam logic [11:0] LINK_END_ALT = 12'hFFF;
   localparam logic [12:0] MAX_BLOCKS   = 13'd4094;

   localparam logic [11:0] NB_RESET   = 12'd391;
   localparam logic [20:0] BB_RESET   = 21'd1024;
   localparam logic [20:0] BB_DEFAULT = 21'd512;

   localparam logic CSR_NUM_BLOCKS  = 1'b0;
   localparam logic CSR_BLOCK_BYTES = 1'b1;

   typedef struct packed {
      logic        we;
      logic [11:0] waddr;
      logic [11:0] wdata;
      logic [11:0] raddr;
   } map_port_type;

endpackage

// File: hw/rtl/bca_ifc.sv
// request and response channel interfaces
interface bca_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] length_bytes;
   logic [11:0] start_block;
   logic [11:0] entry_index;
   logic [11:0] entry_value;
   modport source (output valid, op, length_bytes, start_block, entry_index, entry_value,
                   input ready);
   modport sink (input valid, op, length_bytes, start_block, entry_index, entry_value,
                 output ready);
endinterface

interface bca_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [11:0] first_block;
   logic [11:0] chain_blocks;
   logic [11:0] entry_out;
   logic [11:0] free_count;
   modport source (output valid, status, first_block, chain_blocks, entry_out, free_count,
                   input ready);
   modport sink (input valid, status, first_block, chain_blocks, entry_out, free_count,
                 output ready);
endinterface

// File: hw/rtl/bca_div.sv
// bit-serial divider giving the rounded-up block count of a byte length
module bca_div import bca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [20:0] divisor,
   output logic        done,
   output logic [32:0] need
);
   logic [31:0] quo_ff, quo_in;
   logic [20:0] rem_ff, rem_in;
   logic [20:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [21:0] shifted;
   logic [21:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, div_ff};
      ge      = shifted >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? diff[20:0] : shifted[20:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign need = {1'b0, quo_ff} + {32'd0, (rem_ff != '0)};
endmodule

// File: hw/rtl/bca_map_ram.sv
// link map memory, one write and one registered read per cycle
module bca_map_ram import bca_pkg::*; #(
   parameter int MAP_DEPTH = 4096
) (
   input  logic         clock,
   input  map_port_type port_in,
   output logic [11:0]  rdata
);
   localparam int AW = $clog2(MAP_DEPTH);

   logic [11:0] mem [MAP_DEPTH];
   logic [11:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (port_in.we) begin
         mem[port_in.waddr[AW-1:0]] <= port_in.wdata;
      end
      rdata_ff <= mem[port_in.raddr[AW-1:0]];
   end

   assign rdata = rdata_ff;
endmodule

// File: hw/rtl/block_chain_allocator.sv
// Block chain allocator: one request at a time against a map of 12-bit next-block links held
// in a single-port-read, single-port-write memory. After reset a clearing pass writes every
// map entry to zero; no request is taken during it. Writing num_blocks while idle or during
// a recount starts a recount that reads the N active entries. Allocate runs the serial
// divider, then a pipelined run search, then links the blocks. Check walks the chain block
// by block; free then walks it again to clear the chain. The memory read latency sets the
// per-block cost of a chain walk. A finished result waits in an output register, so the
// next request is taken while it is still unread.
module block_chain_allocator import bca_pkg::*; #(
   parameter int MAP_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   bca_req_if.sink     req,
   bca_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata
);
   localparam logic [12:0] DEPTH_C = 13'(MAP_DEPTH);
   localparam logic [12:0] N_CAP   = (DEPTH_C < MAX_BLOCKS) ? DEPTH_C : MAX_BLOCKS;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RECOUNT  = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_LINK     = 4'd5;
   localparam logic [3:0] S_LINK_END = 4'd6;
   localparam logic [3:0] S_WALK_RD  = 4'd7;
   localparam logic [3:0] S_WALK_EV  = 4'd8;
   localparam logic [3:0] S_LEN      = 4'd9;
   localparam logic [3:0] S_LEN2     = 4'd10;
   localparam logic [3:0] S_FREE_RD  = 4'd11;
   localparam logic [3:0] S_FREE_WR  = 4'd12;
   localparam logic [3:0] S_ENTRY    = 4'd13;
   localparam logic [3:0] S_DONE     = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic [12:0] a_ff, a_in;
   logic        p_ff, p_in;
   logic [11:0] pi_ff, pi_in;
   logic [11:0] run_ff, run_in;
   logic [11:0] prev_ff, prev_in;
   logic        have_prev_ff, have_prev_in;
   logic [32:0] need_ff, need_in;
   logic [11:0] cur_ff, cur_in;
   logic [11:0] k_ff, k_in;
   logic [32:0] prod_ff, prod_in;
   logic [11:0] used_ff, used_in;
   logic [11:0] num_blocks_ff;
   logic [20:0] block_bytes_ff;
   logic [2:0]  op_ff, op_in;
   logic [31:0] len_ff, len_in;
   logic [11:0] start_ff, start_in;
   logic [11:0] idx_ff, idx_in;
   logic [11:0] val_ff, val_in;
   logic [2:0]  st_ff, st_in;
   logic [11:0] first_ff, first_in;
   logic [11:0] cnt_ff, cnt_in;
   logic [11:0] entry_ff, entry_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [11:0] rsp_first_ff, rsp_first_in;
   logic [11:0] rsp_chain_ff, rsp_chain_in;
   logic [11:0] rsp_entry_ff, rsp_entry_in;
   logic [11:0] rsp_free_ff, rsp_free_in;

   map_port_type mp;
   logic [11:0]  rdata;
   logic         div_start;
   logic         div_done;
   logic [32:0]  div_need;
   logic [12:0]  n13;
   logic [11:0]  n_eff;
   logic [20:0]  bb;
   logic         issue;
   logic [11:0]  free_now;
   logic [11:0]  need12;
   logic         req_ready;
   logic         recount_req;

   bca_map_ram #(.MAP_DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .port_in (mp),
      .rdata   (rdata)
   );

   bca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req.length_bytes),
      .divisor  (bb),
      .done     (div_done),
      .need     (div_need)
   );

   always_comb begin
      n13      = ({1'b0, num_blocks_ff} < N_CAP) ? {1'b0, num_blocks_ff} : N_CAP;
      n_eff    = n13[11:0];
      bb       = (block_bytes_ff == '0) ? BB_DEFAULT : block_bytes_ff;
      issue    = a_ff < {1'b0, n_eff};
      free_now = n_eff - used_ff;
      need12   = need_ff[11:0];
      recount_req = csr_we && (csr_index == CSR_NUM_BLOCKS);
   end

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      p_in         = p_ff;
      pi_in        = pi_ff;
      run_in       = run_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      used_in      = used_ff;
      op_in        = op_ff;
      len_in       = len_ff;
      start_in     = start_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      st_in        = st_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      entry_in     = entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_chain_in  = rsp_chain_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_free_in   = rsp_free_ff;
      mp        = '0;
      div_start = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mp.we    = 1'b1;
            mp.waddr = a_ff[11:0];
            a_in     = a_ff + 13'd1;
            if (a_ff == DEPTH_C - 13'd1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (recount_req) begin
               state_in = S_RECOUNT;
               a_in     = '0;
               p_in     = 1'b0;
               used_in  = '0;
            end else begin
               req_ready = 1'b1;
               if (req.valid) begin
                  op_in    = req.op;
                  start_in = req.start_block;
                  idx_in   = req.entry_index;
                  val_in   = req.entry_value;
                  len_in   = req.length_bytes;
                  st_in    = ST_OK;
                  first_in = '0;
                  cnt_in   = '0;
                  entry_in = '0;
                  cur_in   = req.start_block;
                  k_in     = '0;
                  case (req.op)
                     OP_ALLOC: begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                     OP_FREE, OP_CHECK: begin
                        // free treats a zero length as one byte
                        if (req.op == OP_FREE && req.length_bytes == '0) begin
                           len_in = 32'd1;
                        end
                        if (req.start_block == '0 ||
                            (req.op == OP_CHECK && req.length_bytes == '0)) begin
                           state_in = S_DONE;
                        end else begin
                           state_in = S_WALK_RD;
                        end
                     end
                     OP_READ, OP_LOAD: begin
                        if (req.entry_index < n_eff) begin
                           mp.raddr = req.entry_index;
                           state_in = S_ENTRY;
                        end else begin
                           st_in    = ST_RANGE;
                           state_in = S_DONE;
                        end
                     end
                     default: state_in = S_DONE;
                  endcase
               end
            end
         end
         S_RECOUNT: begin
            if (recount_req) begin
               a_in    = '0;
               p_in    = 1'b0;
               used_in = '0;
            end else begin
               mp.raddr = a_ff[11:0];
               p_in     = issue;
               if (issue) begin
                  a_in = a_ff + 13'd1;
               end
               if (p_ff && rdata != '0) begin
                  used_in = used_ff + 12'd1;
               end
               if (!p_ff && !issue) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               need_in = div_need;
               if (div_need == '0) begin
                  state_in = S_DONE;
               end else if (div_need > {21'd0, free_now}) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  a_in     = '0;
                  p_in     = 1'b0;
                  run_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // pipelined search for the first free run of the needed length
            mp.raddr = a_ff[11:0];
            p_in     = issue;
            pi_in    = a_ff[11:0];
            if (issue) begin
               a_in = a_ff + 13'd1;
            end
            if (p_ff) begin
               if (rdata == '0) begin
                  run_in = run_ff + 12'd1;
               end else begin
                  run_in = '0;
               end
            end
            if (p_ff && rdata == '0 && run_ff + 12'd1 == need12) begin
               a_in         = {1'b0, pi_ff - need12 + 12'd1};
               p_in         = 1'b0;
               run_in       = '0;
               have_prev_in = 1'b0;
               state_in     = S_LINK;
            end else if (!p_ff && !issue) begin
               // no run: take free blocks from the bottom
               a_in         = '0;
               p_in         = 1'b0;
               run_in       = '0;
               have_prev_in = 1'b0;
               state_in     = S_LINK;
            end
         end
         S_LINK: begin
            mp.raddr = a_ff[11:0];
            p_in     = issue;
            pi_in    = a_ff[11:0];
            if (issue) begin
               a_in = a_ff + 13'd1;
            end
            if (p_ff && rdata == '0) begin
               if (have_prev_ff) begin
                  mp.we    = 1'b1;
                  mp.waddr = prev_ff;
                  mp.wdata = pi_ff + 12'd2;
               end else begin
                  first_in = pi_ff + 12'd2;
               end
               prev_in      = pi_ff;
               have_prev_in = 1'b1;
               run_in       = run_ff + 12'd1;
               if (run_ff + 12'd1 == need12) begin
                  p_in     = 1'b0;
                  state_in = S_LINK_END;
               end
            end
         end
         S_LINK_END: begin
            mp.we    = 1'b1;
            mp.waddr = prev_ff;
            mp.wdata = LINK_END;
            used_in  = used_ff + need12;
            cnt_in   = need12;
            state_in = S_DONE;
         end
         S_WALK_RD: begin
            if (cur_ff < 12'd2 || {1'b0, cur_ff} >= {1'b0, n_eff} + 13'd2 || k_ff >= n_eff) begin
               st_in    = ST_BADLINK;
               state_in = S_DONE;
            end else begin
               mp.raddr = cur_ff - 12'd2;
               k_in     = k_ff + 12'd1;
               state_in = S_WALK_EV;
            end
         end
         S_WALK_EV: begin
            if (rdata == LINK_END || rdata == LINK_END_ALT) begin
               state_in = S_LEN;
            end else if (rdata == '0) begin
               st_in    = ST_FREEIN;
               state_in = S_DONE;
            end else begin
               cur_in   = rdata;
               state_in = S_WALK_RD;
            end
         end
         S_LEN: begin
            prod_in  = 33'(k_ff) * 33'(bb);
            state_in = S_LEN2;
         end
         S_LEN2: begin
            if (prod_ff < {1'b0, len_ff}) begin
               st_in    = ST_SHORT;
               state_in = S_DONE;
            end else begin
               cnt_in = k_ff;
               if (op_ff == OP_FREE) begin
                  cur_in   = start_ff;
                  run_in   = '0;
                  state_in = S_FREE_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FREE_RD: begin
            mp.raddr = cur_ff - 12'd2;
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            mp.we    = 1'b1;
            mp.waddr = cur_ff - 12'd2;
            cur_in   = rdata;
            run_in   = run_ff + 12'd1;
            if (run_ff + 12'd1 == cnt_ff) begin
               used_in  = used_ff - cnt_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_ENTRY: begin
            if (op_ff == OP_READ) begin
               entry_in = rdata;
            end else begin
               if (rdata == '0 && val_ff != '0) begin
                  used_in = used_ff + 12'd1;
               end else if (rdata != '0 && val_ff == '0) begin
                  used_in = used_ff - 12'd1;
               end
               mp.we    = 1'b1;
               mp.waddr = idx_ff;
               mp.wdata = val_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_first_in  = first_ff;
               rsp_chain_in  = cnt_ff;
               rsp_entry_in  = entry_ff;
               rsp_free_in   = free_now;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         a_ff           <= '0;
         p_ff           <= 1'b0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         num_blocks_ff  <= NB_RESET;
         block_bytes_ff <= BB_RESET;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         p_ff         <= p_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_NUM_BLOCKS) begin
            num_blocks_ff <= csr_wdata[11:0];
         end
         if (csr_we && csr_index == CSR_BLOCK_BYTES) begin
            block_bytes_ff <= csr_wdata;
         end
      end
      pi_ff         <= pi_in;
      run_ff        <= run_in;
      prev_ff       <= prev_in;
      have_prev_ff  <= have_prev_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      prod_ff       <= prod_in;
      op_ff         <= op_in;
      len_ff        <= len_in;
      start_ff      <= start_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      st_ff         <= st_in;
      first_ff      <= first_in;
      cnt_ff        <= cnt_in;
      entry_ff      <= entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_chain_ff  <= rsp_chain_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req.ready        = req_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.first_block  = rsp_first_ff;
   assign rsp.chain_blocks = rsp_chain_ff;
   assign rsp.entry_out    = rsp_entry_ff;
   assign rsp.free_count   = rsp_free_ff;

   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> used_ff <= n_eff)
      else $error("used count exceeds active blocks");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req.ready)
      else $error("request taken during clearing pass");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff != S_IDLE)
      else $error("accepted request did not start");

   a_link_end_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINK_END |-> (have_prev_ff && run_ff == need12))
      else $error("chain closed before all blocks linked");
endmodule
